/* design/npcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared constants and types for the nearest palette color search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

    // Palette size and derived widths
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);
    localparam int PAL_WORD_W      = 24;
    localparam int IDX_W           = 8;
    localparam int CHAN_W          = 8;
    localparam int SQ_W            = 2 * CHAN_W;
    localparam int DIST_W          = SQ_W + 2;
    localparam int WORD_W          = 32;
    localparam int COLOR_W         = 15;
    localparam int FIELD_W         = 5;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Alpha values of a packed palette word
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

    // Classified command passed from the front end to the back end
    typedef struct packed {
        logic                is_query;
        logic                wr_en;     // load that lands inside the palette
        logic [CHAN_W-1:0]   alpha;
        logic [IDX_W-1:0]    entry_index;
        logic [CHAN_W-1:0]   red;       // palette red, or widened query red
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
    } cmd_t;

    // Widen a 5-bit color field to 8 bits: (field << 3) + 4
    function automatic logic [CHAN_W-1:0] widen5(input logic [FIELD_W-1:0] field);
        return {field, 3'b100};
    endfunction

endpackage

/* design/nearest_palette_color_search.sv */
`timescale 1ns / 1ps
// A load returns its word through the front-end queue and the output register;
// a query returns its index once its palette scan is done.
// Throughput: one load per cycle while the output is taken; a query holds the
// back end until its scan ends, as the read port serves one entry per cycle.
// Reset clears the queue and control state; palette contents are undefined
// until loaded (no clearing pass).
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette store with load and nearest-color query: a queued front end feeds
// a back end that writes the palette or scans it for the closest entry.
// ----------------------------------------------------------------------------
module nearest_palette_color_search import npcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [IDX_W-1:0]   s_entry_index,
    input  logic [CHAN_W-1:0]  s_red,
    input  logic [CHAN_W-1:0]  s_green,
    input  logic [CHAN_W-1:0]  s_blue,
    input  logic [COLOR_W-1:0] s_color_15bit,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [WORD_W-1:0]  m_packed_word,
    output logic [IDX_W-1:0]   m_nearest_index
);

    logic                  q_valid;
    cmd_t                  q_cmd;
    logic                  q_pop;
    logic                  ram_we;
    logic [PAL_ADDR_W-1:0] ram_waddr;
    logic [PAL_WORD_W-1:0] ram_wdata;
    logic [PAL_ADDR_W-1:0] ram_raddr;
    logic [PAL_WORD_W-1:0] ram_rdata;

    // Front end: accept and classify
    npcs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_entry_index (s_entry_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_color_15bit (s_color_15bit),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    // Palette memory
    npcs_ram #(
        .WIDTH (PAL_WORD_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Back end: load and search
    npcs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .q_pop           (q_pop),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_packed_word   (m_packed_word),
        .m_nearest_index (m_nearest_index)
    );

endmodule

/* design/npcs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/npcs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_front
// Accepts input transfers, classifies them into commands and holds them in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module npcs_front import npcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [IDX_W-1:0]   s_entry_index,
    input  logic [CHAN_W-1:0]  s_red,
    input  logic [CHAN_W-1:0]  s_green,
    input  logic [CHAN_W-1:0]  s_blue,
    input  logic [COLOR_W-1:0] s_color_15bit,
    output logic               q_valid,
    output cmd_t               q_cmd,
    input  logic               q_pop
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cmd;
    logic       in_range;
    logic       push;

    // Classify the incoming item
    always_comb begin
        in_range = int'(s_entry_index) < PALETTE_ENTRIES;
        cmd = '0;
        cmd.is_query    = (s_kind == KIND_QUERY);
        cmd.entry_index = s_entry_index;
        if (s_kind == KIND_QUERY) begin
            cmd.red   = widen5(s_color_15bit[FIELD_W-1:0]);
            cmd.green = widen5(s_color_15bit[2*FIELD_W-1:FIELD_W]);
            cmd.blue  = widen5(s_color_15bit[3*FIELD_W-1:2*FIELD_W]);
        end else begin
            cmd.red   = s_red;
            cmd.green = s_green;
            cmd.blue  = s_blue;
            cmd.wr_en = in_range;
            cmd.alpha = (in_range && int'(s_entry_index) == PALETTE_ENTRIES - 1)
                        ? ALPHA_CLEAR : ALPHA_OPAQUE;
        end
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    // Queue pointers and fill count
    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

/* design/npcs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_back
// Executes queued commands: a load writes the palette memory and returns the
// packed word; a query scans the palette one entry per cycle through a
// three-stage distance pipeline and returns the nearest index.
// ----------------------------------------------------------------------------
module npcs_back import npcs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  cmd_t                  q_cmd,
    output logic                  q_pop,
    output logic                  ram_we,
    output logic [PAL_ADDR_W-1:0] ram_waddr,
    output logic [PAL_WORD_W-1:0] ram_wdata,
    output logic [PAL_ADDR_W-1:0] ram_raddr,
    input  logic [PAL_WORD_W-1:0] ram_rdata,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [WORD_W-1:0]     m_packed_word,
    output logic [IDX_W-1:0]      m_nearest_index
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;
    localparam logic [PAL_ADDR_W-1:0] LAST_ADDR = PAL_ADDR_W'(PALETTE_ENTRIES - 1);

    logic                  state_reg, state_next;
    logic                  issue_reg, issue_next;
    logic [PAL_ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [CHAN_W-1:0]     qr_reg, qg_reg, qb_reg;
    logic                  s1_valid_reg, s1_last_reg;
    logic [PAL_ADDR_W-1:0] s1_idx_reg;
    logic                  s2_valid_reg, s2_last_reg;
    logic [PAL_ADDR_W-1:0] s2_idx_reg;
    logic [SQ_W-1:0]       sq_r_reg, sq_g_reg, sq_b_reg;
    logic [DIST_W-1:0]     best_dist_reg, best_dist_next;
    logic [PAL_ADDR_W-1:0] best_idx_reg, best_idx_next;
    logic                  m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]     m_word_reg, m_word_next;
    logic [IDX_W-1:0]      m_index_reg, m_index_next;

    logic [CHAN_W-1:0]     pr, pg, pb;
    logic [CHAN_W-1:0]     dr, dg, db;
    logic [DIST_W-1:0]     dist_sum;
    logic                  better;
    logic                  start;

    // Start a command when the output slot is free or being drained
    assign start     = (state_reg == ST_IDLE) && q_valid && (!m_valid_reg || m_ready);
    assign q_pop     = start;
    assign ram_we    = start && !q_cmd.is_query && q_cmd.wr_en;
    assign ram_waddr = q_cmd.entry_index[PAL_ADDR_W-1:0];
    assign ram_wdata = {q_cmd.blue, q_cmd.green, q_cmd.red};
    assign ram_raddr = rd_addr_reg;

    // Stage 2: absolute channel differences of the entry just read
    always_comb begin
        pr = ram_rdata[CHAN_W-1:0];
        pg = ram_rdata[2*CHAN_W-1:CHAN_W];
        pb = ram_rdata[3*CHAN_W-1:2*CHAN_W];
        dr = (qr_reg >= pr) ? qr_reg - pr : pr - qr_reg;
        dg = (qg_reg >= pg) ? qg_reg - pg : pg - qg_reg;
        db = (qb_reg >= pb) ? qb_reg - pb : pb - qb_reg;
    end

    // Stage 3: distance sum and running minimum
    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign better   = dist_sum < best_dist_reg;

    // Control and result path
    always_comb begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        rd_addr_next   = rd_addr_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_word_next    = m_word_reg;
        m_index_next   = m_index_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (q_cmd.is_query) begin
                        state_next     = ST_SCAN;
                        issue_next     = 1'b1;
                        rd_addr_next   = '0;
                        best_dist_next = '1;
                        best_idx_next  = '0;
                    end else begin
                        m_valid_next = 1'b1;
                        m_word_next  = {q_cmd.alpha, q_cmd.blue, q_cmd.green, q_cmd.red};
                        m_index_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                // Address sequencer
                if (issue_reg) begin
                    if (rd_addr_reg == LAST_ADDR) begin
                        issue_next = 1'b0;
                    end else begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
                // Minimum tracking
                if (s2_valid_reg && better) begin
                    best_dist_next = dist_sum;
                    best_idx_next  = s2_idx_reg;
                end
                if (s2_valid_reg && s2_last_reg) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_word_next  = '0;
                    m_index_next = IDX_W'(better ? s2_idx_reg : best_idx_reg);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            issue_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            s1_valid_reg <= (state_reg == ST_SCAN) && issue_reg;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_addr_reg   <= rd_addr_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        m_word_reg    <= m_word_next;
        m_index_reg   <= m_index_next;
        if (start && q_cmd.is_query) begin
            qr_reg <= q_cmd.red;
            qg_reg <= q_cmd.green;
            qb_reg <= q_cmd.blue;
        end
        // Stage 1: tag the read issued this cycle
        s1_idx_reg  <= rd_addr_reg;
        s1_last_reg <= (rd_addr_reg == LAST_ADDR);
        // Stage 2: squares
        s2_idx_reg  <= s1_idx_reg;
        s2_last_reg <= s1_last_reg;
        sq_r_reg    <= dr * dr;
        sq_g_reg    <= dg * dg;
        sq_b_reg    <= db * db;
    end

    assign m_valid         = m_valid_reg;
    assign m_packed_word   = m_word_reg;
    assign m_nearest_index = m_index_reg;

endmodule
